>>> src/fqs_pkg.sv
// Shared types and codes for the FIFO queue with swap.
package fqs_pkg;

   typedef logic signed [31:0] word_type;

   localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [1:0] FUNC_DEQUEUE = 2'd1;
   localparam logic [1:0] FUNC_SWAP    = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_SAME    = 3'd3;
   localparam logic [2:0] ST_INVALID = 3'd4;

   typedef struct packed {
      logic [1:0] func;
      word_type   value;
      logic [3:0] index_a;
      logic [3:0] index_b;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      word_type   out_value;
      logic [4:0] fill_count;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_DEQ     = 5'b00010,
      S_SWAP_RD = 5'b00100,
      S_SWAP_WR = 5'b01000,
      S_RESP    = 5'b10000
   } state_type;

endpackage

>>> src/fqs_ram.sv
// Entry storage: one write port, two registered read ports.
module fqs_ram #(
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  fqs_pkg::word_type   wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr_a,
   input  logic [ADDR_W-1:0]   rd_addr_b,
   output fqs_pkg::word_type   rd_data_a,
   output fqs_pkg::word_type   rd_data_b
);
   import fqs_pkg::*;

   word_type store_ff [DEPTH];
   word_type rd_data_a_ff;
   word_type rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= store_ff[rd_addr_a];
         rd_data_b_ff <= store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

>>> src/fqs_ctrl.sv
// Sequencer: pointers, slot arithmetic and read-modify-write of the entry store.
module fqs_ctrl #(
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fqs_pkg::req_type     req,
   input  logic                 rsp_free,
   output fqs_pkg::result_type  result,
   output logic                 wr_en,
   output logic [ADDR_W-1:0]    wr_addr,
   output fqs_pkg::word_type    wr_data,
   output logic                 rd_en,
   output logic [ADDR_W-1:0]    rd_addr_a,
   output logic [ADDR_W-1:0]    rd_addr_b,
   input  fqs_pkg::word_type    rd_data_a,
   input  fqs_pkg::word_type    rd_data_b
);
   import fqs_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = ((ADDR_W > 4) ? ADDR_W : 4) + 1;
   localparam logic [SUM_W-1:0]  DEPTH_S = SUM_W'(DEPTH);
   localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(DEPTH - 1);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [2:0]        status_ff, status_in;
   word_type          value_ff, value_in;
   logic [ADDR_W-1:0] slot_a_ff, slot_a_in;
   logic [ADDR_W-1:0] slot_b_ff, slot_b_in;
   word_type          temp_ff, temp_in;

   logic [SUM_W-1:0]  head_s, count_s, pos_a, pos_b;
   logic [SUM_W-1:0]  sum_a, sum_b, sum_t;
   logic [ADDR_W-1:0] slot_a, slot_b, slot_t;
   logic              accept;

   // slot = (head + position) mod DEPTH; the sum stays below twice DEPTH
   assign head_s  = SUM_W'(head_ff);
   assign count_s = SUM_W'(count_ff);
   assign pos_a   = SUM_W'(req.index_a);
   assign pos_b   = SUM_W'(req.index_b);
   assign sum_a   = head_s + pos_a;
   assign sum_b   = head_s + pos_b;
   assign sum_t   = head_s + count_s;
   assign slot_a  = ADDR_W'((sum_a >= DEPTH_S) ? sum_a - DEPTH_S : sum_a);
   assign slot_b  = ADDR_W'((sum_b >= DEPTH_S) ? sum_b - DEPTH_S : sum_b);
   assign slot_t  = ADDR_W'((sum_t >= DEPTH_S) ? sum_t - DEPTH_S : sum_t);

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = status_ff;
      value_in  = value_ff;
      slot_a_in = slot_a_ff;
      slot_b_in = slot_b_ff;
      temp_in   = temp_ff;
      wr_en     = 1'b0;
      wr_addr   = slot_t;
      wr_data   = req.value;
      rd_en     = 1'b0;
      rd_addr_a = slot_a;
      rd_addr_b = slot_b;
      result.valid = 1'b0;
      result.data.status     = status_ff;
      result.data.out_value  = value_ff;
      result.data.fill_count = 5'(count_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = ST_OK;
               value_in  = '0;
               state_in  = S_RESP;
               case (req.func)
                  FUNC_ENQUEUE: begin
                     if (count_ff == DEPTH_C) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  FUNC_DEQUEUE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr_a = head_ff;
                        head_in   = (head_ff == LAST_A) ? '0 : head_ff + 1'b1;
                        count_in  = count_ff - 1'b1;
                        state_in  = S_DEQ;
                     end
                  end
                  FUNC_SWAP: begin
                     if (req.index_a == req.index_b) begin
                        status_in = ST_SAME;
                     end else if (pos_a >= count_s || pos_b >= count_s) begin
                        status_in = ST_INVALID;
                     end else begin
                        rd_en     = 1'b1;
                        slot_a_in = slot_a;
                        slot_b_in = slot_b;
                        state_in  = S_SWAP_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DEQ: begin
            value_in = rd_data_a;
            state_in = S_RESP;
         end
         S_SWAP_RD: begin
            wr_en    = 1'b1;
            wr_addr  = slot_a_ff;
            wr_data  = rd_data_b;
            temp_in  = rd_data_a;
            state_in = S_SWAP_WR;
         end
         S_SWAP_WR: begin
            wr_en    = 1'b1;
            wr_addr  = slot_b_ff;
            wr_data  = temp_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               result.valid = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      value_ff  <= value_in;
      slot_a_ff <= slot_a_in;
      slot_b_ff <= slot_b_in;
      temp_ff   <= temp_in;
   end

endmodule

>>> src/fifo_queue_with_swap.sv
// Top level of the FIFO queue with swap: sequencer, entry store and response register.
//
// A queue of DEPTH signed 32-bit entries kept as a ring buffer in one
// synchronous memory (one write port, two registered read ports). Each
// request transfer carries one operation: enqueue, dequeue or swap of two
// positions counted from the head; each produces exactly one response
// transfer with a status, the dequeued value (zero otherwise) and the fill
// count after the operation. One request is handled at a time. An enqueue
// (one entry written) or a refused or rejected operation goes from
// acceptance straight to the response state; a dequeue (one memory read)
// first passes through a state that takes the read data, and a swap through
// write-back states for the first and then the second entry (both entries
// read together, then written back one per cycle over the single write
// port). A new request is taken as soon as the previous result has moved
// into the response register, even if that response is still stalled. The
// store needs no clearing after reset: only written entries are ever read.
module fifo_queue_with_swap #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fqs_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fqs_pkg::rsp_type rsp
);
   import fqs_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   result_type        result;
   logic              rsp_free;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   word_type          wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   word_type          rd_data_a;
   word_type          rd_data_b;

   // the response register can take a result when empty or being drained
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   fqs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_free  (rsp_free),
      .result    (result),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   fqs_ram #(.DEPTH(DEPTH)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // load a finished result, drop the valid once the transfer completes,
   // hold everything while the consumer stalls
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result.data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> src/fqs_checker.sv
// Port-level checks for the FIFO queue with swap, bound to the top level.
module fqs_checker #(
   parameter int DEPTH = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input fqs_pkg::req_type req,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input fqs_pkg::rsp_type rsp
);
   import fqs_pkg::*;

   localparam bit SMALL_Q = (DEPTH < 32);
   localparam logic [4:0] DEPTH_F = 5'(DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("response changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   a_value_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != ST_OK |-> rsp.out_value == '0)
      else $error("nonzero value with error status");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == ST_FULL |-> rsp.fill_count == DEPTH_F)
      else $error("full status without full count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && SMALL_Q |-> rsp.fill_count <= DEPTH_F)
      else $error("fill count beyond depth");

endmodule

bind fifo_queue_with_swap fqs_checker #(.DEPTH(DEPTH)) u_fqs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);
